/* rtl/core/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition now implies consequence in the next cycle
`define MBT_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle check");

// condition now implies consequence in the same cycle
`define MBT_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle check");

`endif

/* rtl/core/mbt_pkg.sv */
package mbt_pkg;

  // per-channel frame buffer
  localparam int BUF_LEN = 256;
  localparam int CNT_W   = $clog2(BUF_LEN + 1);
  localparam int ADDR_W  = $clog2(2 * BUF_LEN);
  localparam int FL_W    = (CNT_W > 9) ? CNT_W : 9;

  // captured header bytes (bytes 0..10)
  localparam int CAP_BYTES = 11;

  // result queue
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  // crc16
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // function codes
  localparam logic [7:0] FC_EXC_BIT   = 8'h80;
  localparam logic [7:0] FC_RD_HOLD   = 8'h03;
  localparam logic [7:0] FC_RD_INPUT  = 8'h04;
  localparam logic [7:0] FC_WR_SINGLE = 8'h06;
  localparam logic [7:0] FC_WR_MULTI  = 8'h10;

  // pdu length pieces
  localparam int PDU_EXC_LEN   = 5;
  localparam int PDU_FIXED_LEN = 8;
  localparam int PDU_MULTI_HDR = 9;
  localparam int PDU_REPLY_HDR = 5;
  localparam int PDU_MIN_CHECK = 4;
  localparam int MULTI_CNT_POS = 7;
  localparam int REPLY_CNT_POS = 3;
  localparam int HDR_MIN       = 2;

  // tag reply limits
  localparam logic [7:0] TAG_MIN_BC  = 8'd8;
  localparam int         TAG_MIN_LEN = 11;
  localparam logic [7:0] MISS_MAX    = 8'd255;

  // configuration register indexes
  localparam logic [2:0] CFG_SNOOP = 3'd0;
  localparam logic [2:0] CFG_HOST  = 3'd1;
  localparam logic [2:0] CFG_GAP   = 3'd2;
  localparam logic [2:0] CFG_TAG   = 3'd3;
  localparam logic [2:0] CFG_MISS  = 3'd4;

  // frame classes
  localparam logic [3:0] CLS_RUNT        = 4'd0;
  localparam logic [3:0] CLS_EXCEPTION   = 4'd1;
  localparam logic [3:0] CLS_READ_REQ    = 4'd2;
  localparam logic [3:0] CLS_WRITE_REQ   = 4'd3;
  localparam logic [3:0] CLS_MULTI_REQ   = 4'd4;
  localparam logic [3:0] CLS_OTHER_REQ   = 4'd5;
  localparam logic [3:0] CLS_READ_REPLY  = 4'd6;
  localparam logic [3:0] CLS_TAG_REPLY   = 4'd7;
  localparam logic [3:0] CLS_WRITE_ACK   = 4'd8;
  localparam logic [3:0] CLS_MULTI_ACK   = 4'd9;
  localparam logic [3:0] CLS_OTHER_REPLY = 4'd10;

  // tag events
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_DETECTED = 2'd1;
  localparam logic [1:0] EV_REMOVED  = 2'd2;

  typedef struct packed {
    logic        source_line;
    logic [8:0]  byte_count;
    logic [8:0]  pdu_length;
    logic        crc_ok;
    logic [7:0]  function_code;
    logic [3:0]  frame_class;
    logic [15:0] field_a;
    logic [15:0] field_b;
    logic [1:0]  tag_event;
    logic [55:0] tag_id;
    logic [7:0]  tag_quality;
    logic        last;
  } result_t;

  // one byte of the reflected modbus crc
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic is_read_fc(input logic [7:0] fc);
    return (fc == FC_RD_HOLD) || (fc == FC_RD_INPUT);
  endfunction

  // first pdu length from function code and byte counts
  function automatic logic [FL_W-1:0] pdu_len(input logic ch, input logic [CNT_W-1:0] n,
                                               input logic [7:0] b1, input logic [7:0] b2,
                                               input logic [7:0] b6);
    logic [FL_W-1:0] nn;
    logic [FL_W-1:0] fl;
    nn = FL_W'(n);
    fl = nn;
    if (n < CNT_W'(HDR_MIN)) begin
      fl = nn;
    end else if ((b1 & FC_EXC_BIT) != 8'h00) begin
      fl = FL_W'(PDU_EXC_LEN);
    end else if (ch) begin
      if (is_read_fc(b1) || (b1 == FC_WR_SINGLE)) begin
        fl = FL_W'(PDU_FIXED_LEN);
      end else if (b1 == FC_WR_MULTI) begin
        fl = (n >= CNT_W'(MULTI_CNT_POS)) ? (FL_W'(PDU_MULTI_HDR) + FL_W'(b6)) : nn;
      end
    end else begin
      if (is_read_fc(b1)) begin
        fl = (n >= CNT_W'(REPLY_CNT_POS)) ? (FL_W'(PDU_REPLY_HDR) + FL_W'(b2)) : nn;
      end else if ((b1 == FC_WR_SINGLE) || (b1 == FC_WR_MULTI)) begin
        fl = FL_W'(PDU_FIXED_LEN);
      end
    end
    return fl;
  endfunction

endpackage

/* rtl/core/modbus_rtu_sniffer_tag_tracker_core.sv */
// Modbus RTU line tap with tag presence tracking. A byte or tick request that closes
// no frame is handled in the idle state. A closing frame is then read back from the
// frame memory one byte per cycle with the CRC updated per byte (one tick can close
// both lines, host first); input is held off during that scan. Results go through a
// four-entry queue, and requests are taken while two or more entries are free. The
// frame memory holds 2 x BUF_LEN bytes and needs no clearing after reset.
module modbus_rtu_sniffer_tag_tracker_core
  import mbt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data[7:0]
  input  logic [1:0]   in_tuser,   // kind[0], channel[1]
  output logic         out_tvalid,
  input  logic         out_tready,
  // byte_count[8:0], pdu_length[17:9], crc_ok[18], function_code[26:19],
  // frame_class[30:27], field_a[46:31], field_b[62:47], tag_event[64:63],
  // tag_id[120:65], tag_quality[128:121], zero fill[135:129]
  output logic [135:0] out_tdata,
  output logic [0:0]   out_tuser,  // source_line[0]
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

  state_t           state_r;
  logic [CNT_W-1:0] fill_r [2];
  logic [15:0]      idle_r [2];
  logic [1:0]       pend_r;
  logic             cur_ch_r;
  logic [CNT_W-1:0] iss_r;
  logic             v_r;
  logic [CNT_W-1:0] pidx_r;
  logic [15:0]      crc_r;
  logic [7:0]       b_r [CAP_BYTES];
  logic [7:0]       want_lo_r;
  logic [7:0]       want_hi_r;
  logic [7:0]       mp_r;
  logic             tp_r;
  logic [15:0]      lra_r;

  logic             snoop_r;
  logic             host_en_r;
  logic [15:0]      gap_r;
  logic [15:0]      tag_reg_r;
  logic [7:0]       thr_r;

  logic [7:0]       mem_r [2 * BUF_LEN];
  logic [7:0]       mem_q_r;

  // request decode
  logic             in_acc;
  logic             in_kind;
  logic             in_ch;
  logic             byte_take;
  logic [CNT_W-1:0] fill_cur;
  logic             room;
  logic [CNT_W-1:0] new_fill;
  logic             wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [1:0]       svc;
  logic [1:0]       gap_hit;
  logic [15:0]      idle_inc [2];
  logic [1:0]       new_pend;
  logic             start_scan;
  logic             start_ch;

  // scan path
  logic [CNT_W-1:0] n_cur;
  logic [7:0]       eb1, eb2, eb6;
  logic [FL_W-1:0]  fl_cur;
  logic [FL_W:0]    pidx_x, flc_x;
  logic             crc_take, lo_take, hi_take, last_byte;

  // frame finish
  logic [FL_W-1:0]  fl_f;
  logic             ok_f;
  logic [7:0]       fc_f;
  logic [15:0]      w23, w45;
  logic [7:0]       mp_n;
  logic             tp_n;
  logic [15:0]      lra_n;
  logic [7:0]       mp_inc;
  result_t          res;
  result_t          head;
  logic             fifo_valid;
  logic [RES_CNT_W-1:0] fifo_cnt;
  logic             push;

  assign in_acc    = in_tvalid && in_tready;
  assign in_kind   = in_tuser[0];
  assign in_ch     = in_tuser[1];
  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE) && (fifo_cnt <= RES_CNT_W'(RES_DEPTH - 2));

  // byte path
  assign byte_take = in_acc && !in_kind && (!in_ch || host_en_r);
  assign fill_cur  = fill_r[in_ch];
  assign room      = fill_cur < CNT_W'(BUF_LEN);
  assign new_fill  = room ? (fill_cur + CNT_W'(1)) : fill_cur;
  assign wr_en     = byte_take && room;
  assign wr_addr   = in_ch ? (ADDR_W'(BUF_LEN) + ADDR_W'(fill_cur)) : ADDR_W'(fill_cur);
  assign rd_addr   = cur_ch_r ? (ADDR_W'(BUF_LEN) + ADDR_W'(iss_r)) : ADDR_W'(iss_r);

  // tick path, per channel
  always_comb begin
    svc[0] = 1'b1;
    svc[1] = host_en_r;
    for (int c = 0; c < 2; c++) begin
      idle_inc[c] = (idle_r[c] == 16'hFFFF) ? idle_r[c] : (idle_r[c] + 16'd1);
      gap_hit[c]  = svc[c] && (fill_r[c] != '0) && (idle_inc[c] >= gap_r);
    end
  end

  // frames to close on this request
  always_comb begin
    new_pend = 2'b00;
    if (in_acc && in_kind) begin
      new_pend = snoop_r ? gap_hit : 2'b00;
    end else if (byte_take && snoop_r && (new_fill >= CNT_W'(BUF_LEN))) begin
      new_pend[in_ch] = 1'b1;
    end
  end

  always_comb begin
    start_scan = 1'b0;
    start_ch   = 1'b0;
    if (state_r == S_IDLE) begin
      start_scan = |new_pend;
      start_ch   = new_pend[1];
    end else if (state_r == S_FIN) begin
      start_scan = pend_r[~cur_ch_r];
      start_ch   = ~cur_ch_r;
    end
  end

  // byte-serial scan: length decision with the byte just read bypassed
  assign n_cur     = fill_r[cur_ch_r];
  assign eb1       = (pidx_r == CNT_W'(1)) ? mem_q_r : b_r[1];
  assign eb2       = (pidx_r == CNT_W'(2)) ? mem_q_r : b_r[2];
  assign eb6       = (pidx_r == CNT_W'(6)) ? mem_q_r : b_r[6];
  assign fl_cur    = pdu_len(cur_ch_r, n_cur, eb1, eb2, eb6);
  assign pidx_x    = (FL_W+1)'(pidx_r);
  assign flc_x     = (FL_W+1)'(fl_cur);
  assign crc_take  = (pidx_x + (FL_W+1)'(2)) < flc_x;
  assign lo_take   = (pidx_x + (FL_W+1)'(2)) == flc_x;
  assign hi_take   = (pidx_x + (FL_W+1)'(1)) == flc_x;
  assign last_byte = (pidx_r + CNT_W'(1)) == n_cur;

  // decode of the scanned frame
  assign fl_f   = pdu_len(cur_ch_r, n_cur, b_r[1], b_r[2], b_r[6]);
  assign fc_f   = b_r[1];
  assign w23    = {b_r[2], b_r[3]};
  assign w45    = {b_r[4], b_r[5]};
  assign ok_f   = (FL_W'(n_cur) >= fl_f) && (fl_f >= FL_W'(PDU_MIN_CHECK)) &&
                  (crc_r == {want_hi_r, want_lo_r});
  assign mp_inc = (mp_r < MISS_MAX) ? (mp_r + 8'd1) : mp_r;

  always_comb begin
    mp_n  = mp_r;
    tp_n  = tp_r;
    lra_n = lra_r;
    res   = '0;
    res.source_line   = cur_ch_r;
    res.byte_count    = 9'(n_cur);
    res.pdu_length    = fl_f[8:0];
    res.crc_ok        = ok_f;
    res.function_code = fc_f;
    res.frame_class   = CLS_RUNT;
    res.tag_event     = EV_NONE;
    res.last          = !pend_r[~cur_ch_r];
    if (n_cur >= CNT_W'(PDU_MIN_CHECK)) begin
      if ((fc_f & FC_EXC_BIT) != 8'h00) begin
        res.frame_class = CLS_EXCEPTION;
        res.field_a     = {8'h00, b_r[2]};
      end else if (cur_ch_r) begin
        res.field_a = w23;
        res.field_b = w45;
        lra_n       = w23;
        if (is_read_fc(fc_f)) begin
          res.frame_class = CLS_READ_REQ;
          if (w23 == tag_reg_r) begin
            mp_n = mp_inc;
            if (tp_r && (mp_inc >= thr_r)) begin
              tp_n          = 1'b0;
              res.tag_event = EV_REMOVED;
            end
          end
        end else if (fc_f == FC_WR_SINGLE) begin
          res.frame_class = CLS_WRITE_REQ;
        end else if (fc_f == FC_WR_MULTI) begin
          res.frame_class = CLS_MULTI_REQ;
        end else begin
          res.frame_class = CLS_OTHER_REQ;
        end
      end else if (is_read_fc(fc_f)) begin
        res.field_a = {8'h00, b_r[2]};
        if (ok_f && (lra_r == tag_reg_r) && (b_r[2] >= TAG_MIN_BC) &&
            (n_cur >= CNT_W'(TAG_MIN_LEN))) begin
          res.frame_class = CLS_TAG_REPLY;
          res.tag_id      = {b_r[3], b_r[4], b_r[5], b_r[6], b_r[7], b_r[8], b_r[9]};
          res.tag_quality = b_r[10];
          mp_n            = 8'd0;
          if (!tp_r) begin
            tp_n          = 1'b1;
            res.tag_event = EV_DETECTED;
          end
        end else begin
          res.frame_class = CLS_READ_REPLY;
        end
      end else begin
        res.field_a = w23;
        res.field_b = w45;
        if (fc_f == FC_WR_SINGLE) res.frame_class = CLS_WRITE_ACK;
        else if (fc_f == FC_WR_MULTI) res.frame_class = CLS_MULTI_ACK;
        else res.frame_class = CLS_OTHER_REPLY;
      end
    end
  end

  assign push = (state_r == S_FIN);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snoop_r   <= 1'b1;
      host_en_r <= 1'b1;
      gap_r     <= 16'd1750;
      tag_reg_r <= 16'd0;
      thr_r     <= 8'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SNOOP: snoop_r   <= cfg_data[0];
        CFG_HOST:  host_en_r <= cfg_data[0];
        CFG_GAP:   gap_r     <= cfg_data;
        CFG_TAG:   tag_reg_r <= cfg_data;
        CFG_MISS:  thr_r     <= cfg_data[7:0];
        default:   ;
      endcase
    end
  end

  // frame memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= in_tdata;
    mem_q_r <= mem_r[rd_addr];
  end

  // control state and scan datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fill_r[0] <= '0;
      fill_r[1] <= '0;
      idle_r[0] <= '0;
      idle_r[1] <= '0;
      pend_r    <= 2'b00;
      cur_ch_r  <= 1'b0;
      v_r       <= 1'b0;
      mp_r      <= 8'd0;
      tp_r      <= 1'b0;
      lra_r     <= 16'd0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (byte_take) begin
            idle_r[in_ch] <= '0;
            fill_r[in_ch] <= new_fill;
          end else if (in_acc && in_kind) begin
            for (int c = 0; c < 2; c++) begin
              if (svc[c]) begin
                if (fill_r[c] == '0) begin
                  idle_r[c] <= '0;
                end else if (gap_hit[c]) begin
                  idle_r[c] <= '0;
                  if (!snoop_r) fill_r[c] <= '0;
                end else begin
                  idle_r[c] <= idle_inc[c];
                end
              end
            end
          end
          pend_r <= new_pend;
        end
        S_SCAN: begin
          if (iss_r < n_cur) begin
            iss_r  <= iss_r + CNT_W'(1);
            v_r    <= 1'b1;
            pidx_r <= iss_r;
          end else begin
            v_r <= 1'b0;
          end
          if (v_r) begin
            if (crc_take) crc_r <= crc16_byte(crc_r, mem_q_r);
            if (lo_take) want_lo_r <= mem_q_r;
            if (hi_take) want_hi_r <= mem_q_r;
            if (pidx_r < CNT_W'(CAP_BYTES)) b_r[pidx_r[3:0]] <= mem_q_r;
            if (last_byte) begin
              state_r <= S_FIN;
              v_r     <= 1'b0;
            end
          end
        end
        S_FIN: begin
          fill_r[cur_ch_r] <= '0;
          pend_r[cur_ch_r] <= 1'b0;
          mp_r             <= mp_n;
          tp_r             <= tp_n;
          lra_r            <= lra_n;
          state_r          <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      // open a scan on the next frame to close
      if (start_scan) begin
        state_r   <= S_SCAN;
        cur_ch_r  <= start_ch;
        iss_r     <= '0;
        v_r       <= 1'b0;
        crc_r     <= CRC_INIT;
        want_lo_r <= 8'h00;
        want_hi_r <= 8'h00;
        for (int k = 0; k < CAP_BYTES; k++) b_r[k] <= 8'h00;
      end
    end
  end

  mbt_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .pop       (out_tready),
    .out_valid (fifo_valid),
    .out_data  (head),
    .count     (fifo_cnt)
  );

  // result channel
  assign out_tvalid   = fifo_valid;
  assign out_tuser[0] = head.source_line;
  assign out_tlast    = head.last;
  assign out_tdata    = {7'd0, head.tag_quality, head.tag_id, head.tag_event, head.field_b,
                         head.field_a, head.frame_class, head.function_code, head.crc_ok,
                         head.pdu_length, head.byte_count};

endmodule

/* rtl/core/mbt_res_fifo.sv */
module mbt_res_fifo
  import mbt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  result_t              push_data,
  input  logic                 pop,
  output logic                 out_valid,
  output result_t              out_data,
  output logic [RES_CNT_W-1:0] count
);

  result_t              q_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] wp_r;
  logic [RES_PTR_W-1:0] rp_r;
  logic [RES_CNT_W-1:0] cnt_r;
  logic                 do_pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rp_r];
  assign count     = cnt_r;
  assign do_pop    = pop && out_valid;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + RES_PTR_W'(1);
      if (do_pop) rp_r <= rp_r + RES_PTR_W'(1);
      if (push && !do_pop) cnt_r <= cnt_r + RES_CNT_W'(1);
      else if (!push && do_pop) cnt_r <= cnt_r - RES_CNT_W'(1);
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_data;
  end

endmodule

/* rtl/core/mbt_checker.sv */
`include "assert_macros.svh"

module mbt_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata
);

  // a waiting result stays offered
  `MBT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

  // class code in range
  `MBT_ASSERT_NOW(a_class, clk, rst_n, out_tvalid, out_tdata[30:27] <= 4'd10)

  // a good crc means a complete first pdu of at least four bytes
  `MBT_ASSERT_NOW(a_crc_len, clk, rst_n, out_tvalid && out_tdata[18], (out_tdata[17:9] <= out_tdata[8:0]) && (out_tdata[17:9] >= 9'd4))

  // tag events come only with tag replies or read requests
  `MBT_ASSERT_NOW(a_event, clk, rst_n, out_tvalid && (out_tdata[64:63] != 2'd0), (out_tdata[30:27] == 4'd7) || (out_tdata[30:27] == 4'd2))

endmodule

bind modbus_rtu_sniffer_tag_tracker_core mbt_checker u_mbt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
